FILE: rtl/slt_pkg.sv
// Shared types and constants for the sorted list table.
// Used by sorted_list_table_core; no other dependencies.
package slt_pkg;

    localparam int unsigned DefCapacity = 16;

    typedef enum logic [1:0] {
        MODE_INSERT = 2'd0,
        MODE_REMOVE = 2'd1,
        MODE_SEARCH = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_PLACE,
        S_FINISH
    } t_state;

endpackage

FILE: rtl/slt_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Standalone; no package dependencies.
module slt_ram #(
    parameter int unsigned Width = 32,
    parameter int unsigned Depth = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(Depth)-1:0] i_wr_addr,
    input  logic [Width-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(Depth)-1:0] i_rd_addr,
    output logic [Width-1:0]         o_rd_data
);

    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: rtl/sorted_list_table_core.sv
// Sorted list table: ascending list of signed values with insert, remove and search.
// Each entry scanned takes a read and a compare state, each entry moved a read and a write;
// a full-list insert or unknown operation skips to S_FINISH. One item is in work at a time.
// The entry RAM's single read port and the shared compare set the rate.
// Reset (synchronous, active low) empties the list; the entry RAM is not cleared.
// Depends on slt_pkg and slt_ram.
module sorted_list_table_core
    import slt_pkg::*;
#(
    parameter int unsigned Capacity = DefCapacity
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_mode,
    input  logic [31:0] i_value,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_status,
    output logic [3:0]  o_position,
    output logic [4:0]  o_count,
    output logic        o_full_res,
    output logic        o_empty_res
);

    localparam int unsigned IW = $clog2(Capacity);
    localparam int unsigned CW = $clog2(Capacity + 1);

    t_state        r_state, n_state;
    t_mode         r_mode, n_mode;
    t_status       r_status, n_status;
    logic [31:0]   r_value, n_value;
    logic [CW-1:0] r_idx, n_idx;
    logic [CW-1:0] r_at, n_at;
    logic [CW-1:0] r_count, n_count;

    logic          r_o_valid, n_o_valid;
    logic [1:0]    r_o_status, n_o_status;
    logic [3:0]    r_o_position, n_o_position;
    logic [4:0]    r_o_count, n_o_count;
    logic          r_o_full, n_o_full;
    logic          r_o_empty, n_o_empty;

    logic          ram_wr_en;
    logic [IW-1:0] ram_wr_addr;
    logic [31:0]   ram_wr_data;
    logic          ram_rd_en;
    logic [IW-1:0] ram_rd_addr;
    logic [31:0]   ram_rd_data;

    logic [CW-1:0] idx_inc;
    logic [CW-1:0] idx_dec;
    logic [CW-1:0] idx_inc2;
    logic          hit;
    logic [31:0]   at_wide;
    logic [31:0]   count_wide;

    slt_ram #(
        .Width(32),
        .Depth(Capacity)
    ) u_ram (
        .i_clk    (i_clk),
        .i_wr_en  (ram_wr_en),
        .i_wr_addr(ram_wr_addr),
        .i_wr_data(ram_wr_data),
        .i_rd_en  (ram_rd_en),
        .i_rd_addr(ram_rd_addr),
        .o_rd_data(ram_rd_data)
    );

    assign idx_inc    = CW'(r_idx + 1'b1);
    assign idx_dec    = CW'(r_idx - 1'b1);
    assign idx_inc2   = CW'(r_idx + 2'd2);
    assign at_wide    = 32'(r_at);
    assign count_wide = 32'(r_count);

    always_comb begin
        if (r_mode == MODE_INSERT) begin
            hit = $signed(r_value) <= $signed(ram_rd_data);
        end else begin
            hit = ram_rd_data == r_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_o_valid <= n_o_valid;
        end
        r_mode       <= n_mode;
        r_status     <= n_status;
        r_value      <= n_value;
        r_idx        <= n_idx;
        r_at         <= n_at;
        r_o_status   <= n_o_status;
        r_o_position <= n_o_position;
        r_o_count    <= n_o_count;
        r_o_full     <= n_o_full;
        r_o_empty    <= n_o_empty;
    end

    always_comb begin
        n_state      = r_state;
        n_mode       = r_mode;
        n_status     = r_status;
        n_value      = r_value;
        n_idx        = r_idx;
        n_at         = r_at;
        n_count      = r_count;
        n_o_valid    = r_o_valid && !i_out_ready;
        n_o_status   = r_o_status;
        n_o_position = r_o_position;
        n_o_count    = r_o_count;
        n_o_full     = r_o_full;
        n_o_empty    = r_o_empty;
        o_in_ready   = 1'b0;
        ram_wr_en    = 1'b0;
        ram_wr_addr  = r_idx[IW-1:0];
        ram_wr_data  = ram_rd_data;
        ram_rd_en    = 1'b0;
        ram_rd_addr  = r_idx[IW-1:0];

        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_mode   = t_mode'(i_mode);
                    n_value  = i_value;
                    n_idx    = '0;
                    n_at     = '0;
                    n_status = ST_DONE;
                    case (i_mode)
                        MODE_INSERT: begin
                            if (r_count >= CW'(Capacity)) begin
                                n_status = ST_FULL;
                                n_state  = S_FINISH;
                            end else if (r_count == '0) begin
                                n_state = S_PLACE;
                            end else begin
                                n_state = S_SCAN_RD;
                            end
                        end
                        MODE_REMOVE, MODE_SEARCH: begin
                            if (r_count == '0) begin
                                n_status = ST_NOT_FOUND;
                                n_state  = S_FINISH;
                            end else begin
                                n_state = S_SCAN_RD;
                            end
                        end
                        default: begin
                            n_state = S_FINISH;
                        end
                    endcase
                end
            end
            S_SCAN_RD: begin
                ram_rd_en = 1'b1;
                n_state   = S_SCAN_CMP;
            end
            S_SCAN_CMP: begin
                if (hit) begin
                    n_at = r_idx;
                    case (r_mode)
                        MODE_INSERT: begin
                            n_idx   = r_count;
                            n_state = S_SHIFT_RD;
                        end
                        MODE_REMOVE: begin
                            if (idx_inc < r_count) begin
                                n_state = S_SHIFT_RD;
                            end else begin
                                n_count = CW'(r_count - 1'b1);
                                n_state = S_FINISH;
                            end
                        end
                        default: begin
                            n_state = S_FINISH;
                        end
                    endcase
                end else if (idx_inc == r_count) begin
                    if (r_mode == MODE_INSERT) begin
                        n_at    = r_count;
                        n_state = S_PLACE;
                    end else begin
                        n_status = ST_NOT_FOUND;
                        n_state  = S_FINISH;
                    end
                end else begin
                    n_idx   = idx_inc;
                    n_state = S_SCAN_RD;
                end
            end
            S_SHIFT_RD: begin
                ram_rd_en = 1'b1;
                if (r_mode == MODE_INSERT) begin
                    ram_rd_addr = idx_dec[IW-1:0];
                end else begin
                    ram_rd_addr = idx_inc[IW-1:0];
                end
                n_state = S_SHIFT_WR;
            end
            S_SHIFT_WR: begin
                ram_wr_en = 1'b1;
                if (r_mode == MODE_INSERT) begin
                    n_idx = idx_dec;
                    if (idx_dec == r_at) begin
                        n_state = S_PLACE;
                    end else begin
                        n_state = S_SHIFT_RD;
                    end
                end else begin
                    n_idx = idx_inc;
                    if (idx_inc2 == r_count) begin
                        n_count = CW'(r_count - 1'b1);
                        n_state = S_FINISH;
                    end else begin
                        n_state = S_SHIFT_RD;
                    end
                end
            end
            S_PLACE: begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = r_at[IW-1:0];
                ram_wr_data = r_value;
                n_count     = CW'(r_count + 1'b1);
                n_state     = S_FINISH;
            end
            S_FINISH: begin
                if (!r_o_valid || i_out_ready) begin
                    n_o_valid    = 1'b1;
                    n_o_status   = r_status;
                    n_o_position = (r_status == ST_DONE) ? at_wide[3:0] : 4'd0;
                    n_o_count    = count_wide[4:0];
                    n_o_full     = r_count == CW'(Capacity);
                    n_o_empty    = r_count == '0;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_o_valid;
    assign o_status    = r_o_status;
    assign o_position  = r_o_position;
    assign o_count     = r_o_count;
    assign o_full_res  = r_o_full;
    assign o_empty_res = r_o_empty;

endmodule

FILE: tb/tb_sorted_list_table_core.sv
// Self-checking testbench for sorted_list_table_core: directed and random insert, remove and
// search transfers under random source bursts and sink stalls, checked against a scoreboard.
// Depends on slt_pkg and the sorted_list_table_core RTL.
module tb_sorted_list_table_core;
    import slt_pkg::*;

    localparam int unsigned Cap = DefCapacity;
    localparam logic [1:0] ModeUnused = 2'd3;
    localparam int unsigned MaxReports = 10;

    typedef struct packed {
        logic [1:0] status;
        logic [3:0] position;
        logic [4:0] count;
        logic       full;
        logic       empty;
    } t_list_result;

    typedef enum {RX_STEADY, RX_CHOPPY, RX_LONG} t_rx_style;

    class t_list_scoreboard;
        logic [31:0]  held [Cap];
        int unsigned  held_count;
        t_list_result pending [$];
        int unsigned  mismatches, orphans, checked;
        int unsigned  n_insert, n_remove, n_search, n_refused, n_missed, n_full, n_empty;

        function void note_transfer(logic [1:0] mode, logic [31:0] value);
            t_list_result r;
            int unsigned  at;
            bit           hit;
            r = '0;
            at = held_count;
            hit = 1'b0;
            case (mode)
                MODE_INSERT: begin
                    n_insert++;
                    if (held_count >= Cap) begin
                        r.status = ST_FULL;
                        n_refused++;
                    end else begin
                        for (int i = 0; i < held_count; i++) begin
                            if (!hit && $signed(value) <= $signed(held[i])) begin
                                at = i;
                                hit = 1'b1;
                            end
                        end
                        for (int i = held_count; i > at; i--) held[i] = held[i-1];
                        held[at] = value;
                        held_count++;
                        r.position = at[3:0];
                    end
                end
                MODE_REMOVE, MODE_SEARCH: begin
                    if (mode == MODE_REMOVE) n_remove++;
                    else n_search++;
                    for (int i = 0; i < held_count; i++) begin
                        if (!hit && held[i] == value) begin
                            at = i;
                            hit = 1'b1;
                        end
                    end
                    if (!hit) begin
                        r.status = ST_NOT_FOUND;
                        n_missed++;
                    end else begin
                        r.position = at[3:0];
                        if (mode == MODE_REMOVE) begin
                            for (int i = at; i + 1 < held_count; i++) held[i] = held[i+1];
                            held_count--;
                        end
                    end
                end
                default: ;
            endcase
            r.status = (r.status == '0) ? ST_DONE : r.status;
            r.count = held_count[4:0];
            r.full = (held_count == Cap);
            r.empty = (held_count == 0);
            if (r.full) n_full++;
            if (r.empty) n_empty++;
            pending.push_back(r);
        endfunction

        function void check_result(t_list_result got);
            t_list_result want;
            if (pending.size() == 0) begin
                orphans++;
                if (orphans + mismatches <= MaxReports)
                    $display("%0t: result transfer with nothing outstanding", $realtime);
                return;
            end
            want = pending.pop_front();
            checked++;
            if (got.status !== want.status || got.position !== want.position ||
                got.count !== want.count || got.full !== want.full ||
                got.empty !== want.empty) begin
                mismatches++;
                if (orphans + mismatches <= MaxReports)
                    $display({"%0t: result %0d expected st=%0d pos=%0d cnt=%0d f=%0d e=%0d,",
                              " got st=%0d pos=%0d cnt=%0d f=%0d e=%0d"},
                             $realtime, checked, want.status, want.position, want.count,
                             want.full, want.empty, got.status, got.position, got.count,
                             got.full, got.empty);
            end
        endfunction

        function bit failed();
            return (mismatches + orphans + pending.size()) != 0;
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [1:0]  i_mode = MODE_SEARCH;
    logic [31:0] i_value = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [1:0]  o_status;
    logic [3:0]  o_position;
    logic [4:0]  o_count;
    logic        o_full_res;
    logic        o_empty_res;

    t_list_scoreboard sb = new;
    t_rx_style        rx_style = RX_CHOPPY;
    int unsigned      rx_run_left = 0;
    int unsigned      burst_left = 0;
    bit               tx_steady = 1'b0;

    sorted_list_table_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_mode      (i_mode),
        .i_value     (i_value),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_status    (o_status),
        .o_position  (o_position),
        .o_count     (o_count),
        .o_full_res  (o_full_res),
        .o_empty_res (o_empty_res)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) sb.note_transfer(i_mode, i_value);
            if (o_out_valid && i_out_ready)
                sb.check_result(t_list_result'({o_status, o_position, o_count,
                                                o_full_res, o_empty_res}));
        end
    end

    always @(posedge i_clk) begin
        if (rx_run_left != 0) begin
            rx_run_left <= rx_run_left - 1;
        end else begin
            case (rx_style)
                RX_STEADY: begin
                    i_out_ready <= 1'b1;
                end
                RX_CHOPPY: begin
                    i_out_ready <= 1'($urandom_range(0, 1));
                    rx_run_left <= $urandom_range(0, 3);
                end
                default: begin
                    i_out_ready <= !i_out_ready;
                    rx_run_left <= i_out_ready ? $urandom_range(4, 20) : $urandom_range(1, 6);
                end
            endcase
        end
    end

    task automatic send_item(input logic [1:0] mode, input logic [31:0] value);
        int unsigned gap;
        if (!tx_steady && burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = $urandom_range(1, 12);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        if (burst_left != 0) burst_left--;
        i_in_valid <= 1'b1;
        i_mode <= mode;
        i_value <= value;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0000_0000;
            3: return 32'hFFFF_FFFF;
            4, 5, 6: return $urandom_range(0, 15) - 32'd8;
            default: return $urandom();
        endcase
    endfunction

    task automatic random_items(input int unsigned n);
        bit          filling;
        int unsigned roll;
        logic [1:0]  mode;
        logic [31:0] value;
        filling = 1'b1;
        repeat (n) begin
            if (sb.held_count == Cap) filling = 1'b0;
            else if (sb.held_count == 0) filling = 1'b1;
            roll = $urandom_range(0, 99);
            if (roll < 3) mode = ModeUnused;
            else if (roll < (filling ? 63 : 28)) mode = MODE_INSERT;
            else if (roll < 80) mode = MODE_REMOVE;
            else mode = MODE_SEARCH;
            if (mode != MODE_INSERT && sb.held_count != 0 && $urandom_range(0, 2) != 0)
                value = sb.held[$urandom_range(0, sb.held_count - 1)];
            else
                value = pick_value();
            send_item(mode, value);
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_item(MODE_SEARCH, 32'd5);
        send_item(MODE_REMOVE, 32'd5);
        send_item(ModeUnused, 32'hFFFF_FFFF);
        send_item(MODE_INSERT, 32'h0000_0000);
        send_item(MODE_INSERT, 32'h7FFF_FFFF);
        send_item(MODE_INSERT, 32'h8000_0000);
        send_item(MODE_INSERT, 32'h0000_0000);
        send_item(MODE_SEARCH, 32'h0000_0000);
        send_item(MODE_REMOVE, 32'h8000_0000);
        send_item(MODE_REMOVE, 32'h7FFF_FFFF);
        send_item(MODE_REMOVE, 32'hFFFF_FFFF);
        for (int k = 1; k <= 14; k++) send_item(MODE_INSERT, -k);
        send_item(MODE_INSERT, 32'h5555_AAAA);
        send_item(MODE_SEARCH, 32'h0000_0000);
        send_item(MODE_REMOVE, -32'sd14);
        wait_drained();

        rx_style <= RX_STEADY;
        tx_steady = 1'b1;
        random_items(320);
        wait_drained();

        rx_style <= RX_CHOPPY;
        tx_steady = 1'b0;
        random_items(330);
        wait_drained();

        rx_style <= RX_LONG;
        tx_steady = 1'b1;
        random_items(320);
        wait_drained();

        tx_steady = 1'b0;
        random_items(330);
        wait_drained();

        repeat (40) @(posedge i_clk);
        $display("Checked %0d results: %0d inserts (%0d refused as full), %0d removes,",
                 sb.checked, sb.n_insert, sb.n_refused, sb.n_remove);
        $display("%0d searches, %0d misses; a full list %0d times, an empty list %0d times.",
                 sb.n_search, sb.n_missed, sb.n_full, sb.n_empty);
        if (!sb.failed()) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("Run timed out with %0d results outstanding.", sb.pending.size());
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
